// ===== sv/tq_pkg.sv =====
package tq_pkg;

   localparam int CAPACITY  = 16;
   localparam int MAX_FIRES = 64;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = 7;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_CANCEL = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_RESOLVE = 3'b100
   } state_type;

endpackage

// ===== sv/timeout_queue_unit.sv =====
// Timer table with add, cancel and tick operations.
// Request channel (req_*): one transfer per operation. func selects add
// (when_due, repeat_every), cancel (target_id) or tick (now_time).
// Response channel (rsp_*): add, cancel and an unknown func give one transfer
// with last set. A tick gives one transfer per fired timer (fired set,
// fire_total counting up, last on the final one), or one empty transfer with
// last when nothing is due; at most MAX_FIRES timers fire per tick.
// Lookup: each table lookup is a scan of CAPACITY entries through one shared
// compare unit, one entry per cycle, followed by a resolve step.
// req_ready is high only while idle.
// The response sits in an output register, so a new request is taken while
// the last response of the previous one still waits; if the receiver stalls,
// the sequencer holds in its resolve step until the register frees up.
// Reset empties the table, clears the id counter and drops rsp_valid.
module timeout_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_when_due,
   input  logic [31:0] req_repeat_every,
   input  logic [31:0] req_target_id,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_id,
   output logic        rsp_ok,
   output logic        rsp_fired,
   output logic [tq_pkg::CNT_W-1:0] rsp_fire_total,
   output logic        rsp_last
);
   import tq_pkg::*;

   // table storage; used bits are flops cleared by reset
   logic [CAPACITY-1:0] used_ff, used_in;
   logic [31:0] slot_id  [CAPACITY];
   logic [63:0] slot_due [CAPACITY];
   logic [31:0] slot_rep [CAPACITY];

   state_type state_ff, state_in;
   logic [31:0] counter_ff, counter_in;

   // latched request
   func_type    func_ff;
   logic [63:0] due_ff;
   logic [31:0] rep_ff;
   logic [31:0] tgt_ff;
   logic [63:0] now_ff;
   logic [31:0] cand_ff;

   // scan results
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [63:0]      best_due_ff, best_due_in;
   logic [31:0]      best_id_ff, best_id_in;
   logic [31:0]      best_rep_ff, best_rep_in;

   // tick bookkeeping: one fired timer is held back until we know if it is last
   logic             pend_ff, pend_in;
   logic [31:0]      pend_id_ff, pend_id_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_id_ff, out_id_in;
   logic             out_ok_ff, out_ok_in;
   logic             out_fired_ff, out_fired_in;
   logic [CNT_W-1:0] out_total_ff, out_total_in;
   logic             out_last_ff, out_last_in;

   // registered table read data for the entry at idx_ff
   logic [31:0] ent_id_ff;
   logic [63:0] ent_due_ff;
   logic [31:0] ent_rep_ff;

   logic        accept;
   logic        out_free;
   logic [31:0] next_id;
   logic [31:0] key_id;
   logic        ent_used;
   logic [31:0] ent_id;
   logic [63:0] ent_due;
   logic [31:0] ent_rep;
   logic        ent_due_ok;
   logic        ent_better;
   logic [64:0] resched_sum;
   logic [63:0] resched_due;
   logic        wr_add;
   logic        wr_fire;
   logic        clr_en;
   logic [IDX_W-1:0] clr_idx;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign out_free       = !out_valid_ff || rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_result_id  = out_id_ff;
   assign rsp_ok         = out_ok_ff;
   assign rsp_fired      = out_fired_ff;
   assign rsp_fire_total = out_total_ff;
   assign rsp_last       = out_last_ff;

   // id counter steps by two, skipping zero on wrap
   always_comb begin
      next_id = counter_ff + 32'd2;
      if (next_id == 32'd0) begin
         next_id = 32'd2;
      end
   end

   // shared compare unit, one table entry per cycle
   assign ent_used   = used_ff[idx_ff];
   assign ent_id     = ent_id_ff;
   assign ent_due    = ent_due_ff;
   assign ent_rep    = ent_rep_ff;
   assign key_id     = (func_ff == FUNC_ADD) ? cand_ff : tgt_ff;
   assign ent_due_ok = ent_used && (ent_due <= now_ff);
   assign ent_better = !best_ff || (ent_due < best_due_ff) ||
                       ((ent_due == best_due_ff) && (ent_id < best_id_ff));

   // saturating reschedule of the chosen periodic timer
   assign resched_sum = {1'b0, best_due_ff} + {33'd0, best_rep_ff};
   assign resched_due = resched_sum[64] ? {64{1'b1}} : resched_sum[63:0];

   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_due_in  = best_due_ff;
      best_id_in   = best_id_ff;
      best_rep_in  = best_rep_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_id_in    = out_id_ff;
      out_ok_in    = out_ok_ff;
      out_fired_in = out_fired_ff;
      out_total_in = out_total_ff;
      out_last_in  = out_last_ff;
      wr_add       = 1'b0;
      wr_fire      = 1'b0;
      clr_en       = 1'b0;
      clr_idx      = match_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (func_type'(req_func) == FUNC_ADD) begin
                  counter_in = next_id;
               end
               idx_in   = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               best_in  = 1'b0;
               pend_in  = 1'b0;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ent_used && (ent_id == key_id) && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = idx_ff;
            end
            if (!ent_used && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (ent_due_ok && ent_better) begin
               best_in     = 1'b1;
               best_idx_in = idx_ff;
               best_due_in = ent_due;
               best_id_in  = ent_id;
               best_rep_in = ent_rep;
            end
            if (idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_RESOLVE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESOLVE: begin
            case (func_ff)
               FUNC_ADD: begin
                  if (out_free) begin
                     out_valid_in = 1'b1;
                     out_fired_in = 1'b0;
                     out_total_in = '0;
                     out_last_in  = 1'b1;
                     if (!match_ff && free_ff) begin
                        wr_add    = 1'b1;
                        out_id_in = cand_ff;
                        out_ok_in = 1'b1;
                     end else begin
                        out_id_in = '0;
                        out_ok_in = 1'b0;
                     end
                     state_in = ST_IDLE;
                  end
               end
               FUNC_CANCEL: begin
                  if (out_free) begin
                     clr_en       = match_ff;
                     out_valid_in = 1'b1;
                     out_id_in    = tgt_ff;
                     out_ok_in    = match_ff;
                     out_fired_in = 1'b0;
                     out_total_in = '0;
                     out_last_in  = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               FUNC_TICK: begin
                  if (best_ff) begin
                     if (pend_ff) begin
                        // another fire follows, so the held one is not last
                        if (out_free) begin
                           out_valid_in = 1'b1;
                           out_id_in    = pend_id_ff;
                           out_ok_in    = 1'b0;
                           out_fired_in = 1'b1;
                           out_total_in = count_ff;
                           out_last_in  = 1'b0;
                           pend_in      = 1'b0;
                        end
                     end else begin
                        wr_fire    = 1'b1;
                        clr_en     = (best_rep_ff == 32'd0);
                        clr_idx    = best_idx_ff;
                        pend_in    = 1'b1;
                        pend_id_in = best_id_ff;
                        count_in   = count_ff + 1'b1;
                        idx_in     = '0;
                        best_in    = 1'b0;
                        if (count_ff + 1'b1 != CNT_W'(MAX_FIRES)) begin
                           state_in = ST_SCAN;
                        end
                     end
                  end else if (out_free) begin
                     out_valid_in = 1'b1;
                     out_id_in    = pend_ff ? pend_id_ff : 32'd0;
                     out_ok_in    = 1'b0;
                     out_fired_in = pend_ff;
                     out_total_in = count_ff;
                     out_last_in  = 1'b1;
                     pend_in      = 1'b0;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     out_valid_in = 1'b1;
                     out_id_in    = '0;
                     out_ok_in    = 1'b0;
                     out_fired_in = 1'b0;
                     out_total_in = '0;
                     out_last_in  = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_add) begin
         used_in[free_idx_ff] = 1'b1;
      end
      if (clr_en) begin
         used_in[clr_idx] = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         due_ff  <= req_when_due;
         rep_ff  <= req_repeat_every;
         tgt_ff  <= req_target_id;
         now_ff  <= req_now_time;
         cand_ff <= next_id;
      end
      idx_ff       <= idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      best_due_ff  <= best_due_in;
      best_id_ff   <= best_id_in;
      best_rep_ff  <= best_rep_in;
      pend_ff      <= pend_in;
      pend_id_ff   <= pend_id_in;
      count_ff     <= count_in;
      out_id_ff    <= out_id_in;
      out_ok_ff    <= out_ok_in;
      out_fired_ff <= out_fired_in;
      out_total_ff <= out_total_in;
      out_last_ff  <= out_last_in;
   end

   // timer table: one write port, registered read at the next scan index
   always_ff @(posedge clock) begin
      if (wr_add) begin
         slot_id[free_idx_ff]  <= cand_ff;
         slot_due[free_idx_ff] <= due_ff;
         slot_rep[free_idx_ff] <= rep_ff;
      end else if (wr_fire) begin
         slot_due[best_idx_ff] <= resched_due;
      end
      ent_id_ff  <= slot_id[idx_in];
      ent_rep_ff <= slot_rep[idx_in];
      // a reschedule lands in the same edge as the rescan restarts
      if (wr_fire && (best_idx_ff == idx_in)) begin
         ent_due_ff <= resched_due;
      end else begin
         ent_due_ff <= slot_due[idx_in];
      end
   end

endmodule
